[rtl/arm_data_processing_alu_top_defines.svh]
// ----------------------------------------------------------------------------
// ARM data-processing ALU: assertion macros
// Clocked assertion wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ARM_DATA_PROCESSING_ALU_TOP_DEFINES_SVH
`define ARM_DATA_PROCESSING_ALU_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define ADPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define ADPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ADPA_ASSERT(label, prop, msg)
`define ADPA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/adpa_pkg.sv]
// ----------------------------------------------------------------------------
// ARM data-processing ALU package
// Opcode and shift codes, and the item formats passed between the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adpa_pkg;

  // Data-processing opcodes, instruction bits 24:21
  typedef enum logic [3:0] {
    OPC_AND = 4'd0,
    OPC_EOR = 4'd1,
    OPC_SUB = 4'd2,
    OPC_RSB = 4'd3,
    OPC_ADD = 4'd4,
    OPC_ADC = 4'd5,
    OPC_SBC = 4'd6,
    OPC_RSC = 4'd7,
    OPC_TST = 4'd8,
    OPC_TEQ = 4'd9,
    OPC_CMP = 4'd10,
    OPC_CMN = 4'd11,
    OPC_ORR = 4'd12,
    OPC_MOV = 4'd13,
    OPC_BIC = 4'd14,
    OPC_MVN = 4'd15
  } opcode_e;

  // Shift types, instruction bits 6:5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  localparam logic [3:0] REG_PC = 4'd15;

  // Decoded and shifted item, front to back
  typedef struct packed {
    logic [31:0] op2;
    logic        shift_carry;
    logic [31:0] rn;
    opcode_e     opcode;
    logic        set_flags;
    logic [3:0]  rd;
    logic [3:0]  flags_in;
    logic        has_spsr;
    logic        undef;
  } front_item_t;

  // Finished result item
  typedef struct packed {
    logic [31:0] result_value;
    logic [3:0]  dest_index;
    logic        write_dest;
    logic [3:0]  flags_out;
    logic        restore_from_spsr;
    logic        status;
  } result_t;

endpackage

`default_nettype wire

[rtl/adpa_fifo.sv]
// ----------------------------------------------------------------------------
// ARM data-processing ALU queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adpa_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/adpa_front.sv]
// ----------------------------------------------------------------------------
// ARM data-processing ALU front end
// Decodes the instruction, flags bad encodings and runs the barrel shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adpa_front
  import adpa_pkg::*;
(
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] rn_value_i,
  input  wire logic [31:0] rm_value_i,
  input  wire logic [31:0] rs_value_i,
  input  wire logic [3:0]  flags_in_i,
  input  wire logic        mode_has_spsr_i,
  output front_item_t      item_o
);

  logic [31:0] op2;
  logic        sc;
  logic        is_cmp;
  opcode_e     opcode;

  assign opcode = opcode_e'(instruction_i[24:21]);
  assign is_cmp = (opcode == OPC_TST) || (opcode == OPC_TEQ) ||
                  (opcode == OPC_CMP) || (opcode == OPC_CMN);

  // Barrel shifter: operand two and shifter carry-out
  always_comb begin
    logic [4:0]         rot;
    logic [63:0]        imm_rot;
    logic [4:0]         imm_amt;
    logic [7:0]         reg_amt;
    logic [5:0]         amt;
    logic [4:0]         ror_amt;
    logic               pass;
    logic               rrx;
    logic [32:0]        lsl_w;
    logic [32:0]        lsr_w;
    logic signed [32:0] asr_w;
    logic [63:0]        ror_w;
    logic               cin;
    shift_e             stype;

    cin     = flags_in_i[1];
    stype   = shift_e'(instruction_i[6:5]);
    rot     = {instruction_i[11:8], 1'b0};
    imm_rot = {24'd0, instruction_i[7:0], 24'd0, instruction_i[7:0]} >> rot;
    imm_amt = instruction_i[11:7];
    reg_amt = rs_value_i[7:0];
    pass    = 1'b0;
    rrx     = 1'b0;

    // Pick the shift amount; immediate shifts by zero become 32, RRX or a pass
    if (!instruction_i[4]) begin
      ror_amt = imm_amt;
      if (imm_amt == '0) begin
        pass = (stype == SH_LSL);
        rrx  = (stype == SH_ROR);
        amt  = 6'd32;
      end else begin
        amt = {1'b0, imm_amt};
      end
    end else begin
      ror_amt = reg_amt[4:0];
      pass    = (reg_amt == '0);
      amt     = (reg_amt > 8'd33) ? 6'd33 : reg_amt[5:0];
    end

    lsl_w = {1'b0, rm_value_i} << amt;
    lsr_w = {rm_value_i, 1'b0} >> amt;
    asr_w = $signed({rm_value_i, 1'b0}) >>> amt;
    ror_w = {rm_value_i, rm_value_i} >> ror_amt;

    if (instruction_i[25]) begin
      op2 = imm_rot[31:0];
      sc  = (rot == '0) ? cin : imm_rot[31];
    end else if (pass) begin
      op2 = rm_value_i;
      sc  = cin;
    end else if (rrx) begin
      op2 = {cin, rm_value_i[31:1]};
      sc  = rm_value_i[0];
    end else begin
      case (stype)
        SH_LSL: begin
          op2 = lsl_w[31:0];
          sc  = lsl_w[32];
        end
        SH_LSR: begin
          op2 = lsr_w[32:1];
          sc  = lsr_w[0];
        end
        SH_ASR: begin
          op2 = asr_w[32:1];
          sc  = asr_w[0];
        end
        default: begin
          op2 = ror_w[31:0];
          sc  = ror_w[31];
        end
      endcase
    end
  end

  // Pack the decoded item
  always_comb begin
    item_o.op2         = op2;
    item_o.shift_carry = sc;
    item_o.rn          = rn_value_i;
    item_o.opcode      = opcode;
    item_o.set_flags   = instruction_i[20];
    item_o.rd          = instruction_i[15:12];
    item_o.flags_in    = flags_in_i;
    item_o.has_spsr    = mode_has_spsr_i;
    item_o.undef       = (!instruction_i[25] && instruction_i[4] && instruction_i[7]) ||
                         (is_cmp && !instruction_i[20]);
  end

endmodule

`default_nettype wire

[rtl/adpa_back.sv]
// ----------------------------------------------------------------------------
// ARM data-processing ALU back end
// Runs the opcode on Rn and operand two and forms Rd, NZCV and the status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adpa_back
  import adpa_pkg::*;
(
  input  front_item_t item_i,
  output result_t     result_o
);

  logic [31:0] add_a, add_b, res;
  logic        add_c;
  logic [32:0] sum;
  logic        is_arith, is_cmp;
  logic        cin;
  logic        nf, zf, cf, vf;
  logic [31:0] alu_value;

  assign cin = item_i.flags_in[1];

  // Select adder operands per opcode
  always_comb begin
    add_a    = item_i.rn;
    add_b    = item_i.op2;
    add_c    = 1'b0;
    is_arith = 1'b1;
    is_cmp   = 1'b0;
    res      = '0;
    unique case (item_i.opcode) inside
      OPC_SUB, OPC_CMP: begin
        add_b = ~item_i.op2;
        add_c = 1'b1;
      end
      OPC_RSB: begin
        add_a = item_i.op2;
        add_b = ~item_i.rn;
        add_c = 1'b1;
      end
      OPC_ADD, OPC_CMN: begin
        add_c = 1'b0;
      end
      OPC_ADC: begin
        add_c = cin;
      end
      OPC_SBC: begin
        add_b = ~item_i.op2;
        add_c = cin;
      end
      OPC_RSC: begin
        add_a = item_i.op2;
        add_b = ~item_i.rn;
        add_c = cin;
      end
      OPC_AND, OPC_TST: begin
        is_arith = 1'b0;
        res      = item_i.rn & item_i.op2;
      end
      OPC_EOR, OPC_TEQ: begin
        is_arith = 1'b0;
        res      = item_i.rn ^ item_i.op2;
      end
      OPC_ORR: begin
        is_arith = 1'b0;
        res      = item_i.rn | item_i.op2;
      end
      OPC_MOV: begin
        is_arith = 1'b0;
        res      = item_i.op2;
      end
      OPC_BIC: begin
        is_arith = 1'b0;
        res      = item_i.rn & ~item_i.op2;
      end
      default: begin
        is_arith = 1'b0;
        res      = ~item_i.op2;
      end
    endcase
    is_cmp = (item_i.opcode == OPC_TST) || (item_i.opcode == OPC_TEQ) ||
             (item_i.opcode == OPC_CMP) || (item_i.opcode == OPC_CMN);
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};

  // Form the value and the NZCV flags
  always_comb begin
    alu_value = is_arith ? sum[31:0] : res;
    nf        = alu_value[31];
    zf        = (alu_value == '0);
    cf        = is_arith ? sum[32] : item_i.shift_carry;
    vf        = is_arith ? (~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]))
                         : item_i.flags_in[0];
  end

  // Decide write-back, flag update, restore and status
  always_comb begin
    logic       undef;
    logic       wr;
    logic       restore;
    logic [3:0] fout;
    undef   = item_i.undef;
    wr      = 1'b0;
    restore = 1'b0;
    fout    = item_i.flags_in;
    if (!item_i.undef) begin
      if (is_cmp) begin
        fout = {nf, zf, cf, vf};
      end else if (item_i.set_flags && (item_i.rd == REG_PC)) begin
        if (item_i.has_spsr) begin
          wr      = 1'b1;
          restore = 1'b1;
        end else begin
          undef = 1'b1;
        end
      end else begin
        wr = 1'b1;
        if (item_i.set_flags) begin
          fout = {nf, zf, cf, vf};
        end
      end
    end
    result_o.result_value      = wr ? alu_value : '0;
    result_o.dest_index        = item_i.rd;
    result_o.write_dest        = wr;
    result_o.flags_out         = fout;
    result_o.restore_from_spsr = restore;
    result_o.status            = undef;
  end

endmodule

`default_nettype wire

[rtl/arm_data_processing_alu_top.sv]
// ARMv5 data-processing execute block. Each item is one data-processing
// instruction word with its Rn, Rm and Rs values, NZCV flags and SPSR flag;
// each item gives exactly one result: Rd value and write enable, new NZCV,
// a CPSR-from-SPSR request and an undefined-instruction status. The block
// takes one item per cycle and keeps that rate as long as pop keeps up.
// Inside, the front end decodes and shifts into a queue, and the back end
// runs the ALU into the output queue, whose head is on the result ports.
// QueueDepth sets both queues (at least 2).

// ----------------------------------------------------------------------------
// ARM data-processing ALU top level
// Front end, decoupling queue, back end and output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arm_data_processing_alu_top_defines.svh"

module arm_data_processing_alu_top
  import adpa_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] rn_value_i,
  input  wire logic [31:0] rm_value_i,
  input  wire logic [31:0] rs_value_i,
  input  wire logic [3:0]  flags_in_i,
  input  wire logic        mode_has_spsr_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [31:0]      result_value_o,
  output logic [3:0]       dest_index_o,
  output logic             write_dest_o,
  output logic [3:0]       flags_out_o,
  output logic             restore_from_spsr_o,
  output logic             status_o
);

  localparam int unsigned FrontW  = $bits(front_item_t);
  localparam int unsigned ResultW = $bits(result_t);

  front_item_t            front_item, mid_item;
  logic [FrontW-1:0]      mid_data;
  logic                   mid_empty;
  result_t                back_result, out_result;
  logic [ResultW-1:0]     out_data;
  logic                   out_full;
  logic                   advance;

  // Decode and shift the incoming item
  adpa_front u_front (
    .instruction_i   (instruction_i),
    .rn_value_i      (rn_value_i),
    .rm_value_i      (rm_value_i),
    .rs_value_i      (rs_value_i),
    .flags_in_i      (flags_in_i),
    .mode_has_spsr_i (mode_has_spsr_i),
    .item_o          (front_item)
  );

  // Hold decoded items between the front and back ends
  adpa_fifo #(
    .Width (FrontW),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_item),
    .full_o  (full_o),
    .pop_i   (advance),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_item = front_item_t'(mid_data);
  assign advance  = !mid_empty && !out_full;

  // Execute the opcode
  adpa_back u_back (
    .item_i   (mid_item),
    .result_o (back_result)
  );

  // Hold finished results until popped
  adpa_fifo #(
    .Width (ResultW),
    .Depth (QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .data_i  (back_result),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_data),
    .empty_o (empty_o)
  );

  // Drive the result ports from the queue head
  assign out_result          = result_t'(out_data);
  assign result_value_o      = out_result.result_value;
  assign dest_index_o        = out_result.dest_index;
  assign write_dest_o        = out_result.write_dest;
  assign flags_out_o         = out_result.flags_out;
  assign restore_from_spsr_o = out_result.restore_from_spsr;
  assign status_o            = out_result.status;

  // An accepted item must reach the decoupling queue
  `ADPA_ASSERT(a_push_lands, (push_i && !full_o) |=> !mid_empty, "accepted item lost")
  // A moved item must show on the result side next cycle
  `ADPA_ASSERT(a_advance_shows, advance |=> !empty_o, "advanced item not visible")
  // An undefined result never writes Rd or restores the CPSR
  `ADPA_ASSERT(a_undef_quiet,
    (!empty_o && status_o) |-> (!write_dest_o && !restore_from_spsr_o),
    "undefined item writes state")

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// ARM data-processing ALU testbench
// Drives data-processing instructions into the queue-style input, predicts
// each result with a behavioural ALU and barrel shifter of its own, and
// checks every popped result field by field, with random idling on both
// sides, a long receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import adpa_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // One instruction with its operands, as pushed into the block
  typedef struct packed {
    logic [31:0] ins;
    logic [31:0] rn;
    logic [31:0] rm;
    logic [31:0] rs;
    logic [3:0]  flags;
    logic        spsr;
  } dp_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  logic [31:0] instruction_i;
  logic [31:0] rn_value_i;
  logic [31:0] rm_value_i;
  logic [31:0] rs_value_i;
  logic [3:0]  flags_in_i;
  logic        mode_has_spsr_i;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [31:0] result_value_o;
  logic [3:0]  dest_index_o;
  logic        write_dest_o;
  logic [3:0]  flags_out_o;
  logic        restore_from_spsr_o;
  logic        status_o;

  result_t     pending_results[$];
  result_t     want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          rx_hold_cycles = 0;
  int          rx_gap = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  arm_data_processing_alu_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push_i),
    .full_o              (full_o),
    .instruction_i       (instruction_i),
    .rn_value_i          (rn_value_i),
    .rm_value_i          (rm_value_i),
    .rs_value_i          (rs_value_i),
    .flags_in_i          (flags_in_i),
    .mode_has_spsr_i     (mode_has_spsr_i),
    .empty_o             (empty_o),
    .pop_i               (pop_i),
    .result_value_o      (result_value_o),
    .dest_index_o        (dest_index_o),
    .write_dest_o        (write_dest_o),
    .flags_out_o         (flags_out_o),
    .restore_from_spsr_o (restore_from_spsr_o),
    .status_o            (status_o)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Behavioural ALU
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotate_right(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] w;
    w = {v, v} >> n;
    return w[31:0];
  endfunction

  // Return {carry_out, operand_two}
  function automatic logic [32:0] barrel_shift(input logic [31:0] ins, input logic [31:0] rm,
                                               input logic [31:0] rs, input logic cin);
    logic [31:0] val;
    logic        cy;
    shift_e      kind;
    int          n;
    kind = shift_e'(ins[6:5]);
    if (ins[25]) begin
      // Rotated 8-bit immediate
      val = rotate_right({24'd0, ins[7:0]}, {ins[11:8], 1'b0});
      cy  = (ins[11:8] == 4'd0) ? cin : val[31];
    end else if (!ins[4]) begin
      // Shift by immediate; zero encodes LSR #32, ASR #32 and RRX
      n = int'(ins[11:7]);
      case (kind)
        SH_LSL: begin
          if (n == 0) {cy, val} = {cin, rm};
          else begin val = rm << n; cy = rm[32 - n]; end
        end
        SH_LSR: begin
          if (n == 0) begin val = '0; cy = rm[31]; end
          else begin val = rm >> n; cy = rm[n - 1]; end
        end
        SH_ASR: begin
          if (n == 0) begin val = {32{rm[31]}}; cy = rm[31]; end
          else begin val = 32'($signed(rm) >>> n); cy = rm[n - 1]; end
        end
        default: begin
          if (n == 0) begin val = {cin, rm[31:1]}; cy = rm[0]; end
          else begin val = rotate_right(rm, 5'(n)); cy = rm[n - 1]; end
        end
      endcase
    end else begin
      // Shift by Rs[7:0]
      n = int'(rs[7:0]);
      if (n == 0) begin
        {cy, val} = {cin, rm};
      end else begin
        case (kind)
          SH_LSL: begin
            if (n < 32) begin val = rm << n; cy = rm[32 - n]; end
            else begin val = '0; cy = (n == 32) ? rm[0] : 1'b0; end
          end
          SH_LSR: begin
            if (n < 32) begin val = rm >> n; cy = rm[n - 1]; end
            else begin val = '0; cy = (n == 32) ? rm[31] : 1'b0; end
          end
          SH_ASR: begin
            if (n < 32) begin val = 32'($signed(rm) >>> n); cy = rm[n - 1]; end
            else begin val = {32{rm[31]}}; cy = rm[31]; end
          end
          default: begin
            if (rs[4:0] == 5'd0) begin val = rm; cy = rm[31]; end
            else begin val = rotate_right(rm, rs[4:0]); cy = rm[int'(rs[4:0]) - 1]; end
          end
        endcase
      end
    end
    return {cy, val};
  endfunction

  // Return {overflow, carry_out, sum}
  function automatic logic [33:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                 input logic c);
    logic [32:0] sum;
    logic [31:0] ovf;
    sum = {1'b0, a} + {1'b0, b} + {32'd0, c};
    ovf = ~(a ^ b) & (a ^ sum[31:0]);
    return {ovf[31], sum};
  endfunction

  function automatic result_t predict_alu(input dp_item_t it);
    result_t     r;
    opcode_e     opc;
    logic        set_flags;
    logic        is_cmp;
    logic        undef;
    logic        wr;
    logic        restore;
    logic        cf;
    logic        vf;
    logic        sc;
    logic [3:0]  rd;
    logic [3:0]  nzcv;
    logic [3:0]  fout;
    logic [31:0] op2;
    logic [31:0] res;
    logic [32:0] shv;
    opc       = opcode_e'(it.ins[24:21]);
    set_flags = it.ins[20];
    rd        = it.ins[15:12];
    cf        = it.flags[1];
    vf        = it.flags[0];
    is_cmp    = (it.ins[24:23] == 2'b10);
    undef     = (!it.ins[25] && it.ins[4] && it.ins[7]) || (is_cmp && !set_flags);
    shv       = barrel_shift(it.ins, it.rm, it.rs, it.flags[1]);
    op2       = shv[31:0];
    sc        = shv[32];
    case (opc)
      OPC_AND, OPC_TST: begin res = it.rn & op2; cf = sc; end
      OPC_EOR, OPC_TEQ: begin res = it.rn ^ op2; cf = sc; end
      OPC_SUB, OPC_CMP: {vf, cf, res} = add_with_carry(it.rn, ~op2, 1'b1);
      OPC_RSB:          {vf, cf, res} = add_with_carry(op2, ~it.rn, 1'b1);
      OPC_ADD, OPC_CMN: {vf, cf, res} = add_with_carry(it.rn, op2, 1'b0);
      OPC_ADC:          {vf, cf, res} = add_with_carry(it.rn, op2, it.flags[1]);
      OPC_SBC:          {vf, cf, res} = add_with_carry(it.rn, ~op2, it.flags[1]);
      OPC_RSC:          {vf, cf, res} = add_with_carry(op2, ~it.rn, it.flags[1]);
      OPC_ORR:          begin res = it.rn | op2; cf = sc; end
      OPC_MOV:          begin res = op2; cf = sc; end
      OPC_BIC:          begin res = it.rn & ~op2; cf = sc; end
      default:          begin res = ~op2; cf = sc; end
    endcase
    nzcv    = {res[31], res == 32'd0, cf, vf};
    fout    = it.flags;
    wr      = 1'b0;
    restore = 1'b0;
    if (!undef) begin
      if (is_cmp) begin
        fout = nzcv;
      end else if (set_flags && rd == REG_PC) begin
        // Flag-setting write to the PC: restore from SPSR where there is one
        if (it.spsr) begin
          wr      = 1'b1;
          restore = 1'b1;
        end else begin
          undef = 1'b1;
        end
      end else begin
        wr = 1'b1;
        if (set_flags) fout = nzcv;
      end
    end
    r.result_value      = wr ? res : 32'd0;
    r.dest_index        = rd;
    r.write_dest        = wr;
    r.flags_out         = undef ? it.flags : fout;
    r.restore_from_spsr = restore;
    r.status            = undef;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] build_instr(input logic imm, input opcode_e opc,
                                              input logic set_flags, input logic [3:0] rd,
                                              input logic [11:0] op12);
    return {4'hE, 2'b00, imm, opc, set_flags, 4'h3, rd, op12};
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed instructions; a few undefined encodings mixed in
  function automatic dp_item_t rand_item();
    dp_item_t it;
    it.ins = $urandom();
    if (it.ins[24:23] == 2'b10 && $urandom_range(0, 15) != 0) it.ins[20] = 1'b1;
    if (!it.ins[25] && it.ins[4] && $urandom_range(0, 15) != 0) it.ins[7] = 1'b0;
    if ($urandom_range(0, 7) == 0) it.ins[15:12] = REG_PC;
    it.rn = rand_operand();
    it.rm = rand_operand();
    it.rs = $urandom();
    case ($urandom_range(0, 3))
      0:       it.rs[7:0] = 8'($urandom_range(0, 31));
      1:       it.rs[7:0] = ($urandom_range(0, 1) != 0) ? 8'd32 : 8'd0;
      2:       it.rs[7:0] = 8'($urandom_range(32, 255));
      default: ;
    endcase
    it.flags = 4'($urandom_range(0, 15));
    it.spsr  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one item until the block takes it, then log its prediction
  task automatic send_item(input dp_item_t it);
    int gap;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) begin
        @(negedge clk_i);
        push_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    push_i          <= 1'b1;
    instruction_i   <= it.ins;
    rn_value_i      <= it.rn;
    rm_value_i      <= it.rm;
    rs_value_i      <= it.rs;
    flags_in_i      <= it.flags;
    mode_has_spsr_i <= it.spsr;
    do @(posedge clk_i); while (full_o);
    pending_results.push_back(predict_alu(it));
  endtask

  task automatic send_fields(input logic [31:0] ins, input logic [31:0] rn,
                             input logic [31:0] rm, input logic [31:0] rs,
                             input logic [3:0] flags, input logic spsr);
    dp_item_t it;
    it = '{ins: ins, rn: rn, rm: rm, rs: rs, flags: flags, spsr: spsr};
    send_item(it);
  endtask

  // Drop push and hold until every predicted result has been popped
  task automatic wait_drain();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall in random bursts, or for a requested hold-off
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      pop_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 16);
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  // Compare each popped item against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_value_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_value", want.result_value, result_value_o);
        check_field("dest_index", 32'(want.dest_index), 32'(dest_index_o));
        check_field("write_dest", 32'(want.write_dest), 32'(write_dest_o));
        check_field("flags_out", 32'(want.flags_out), 32'(flags_out_o));
        check_field("restore_from_spsr", 32'(want.restore_from_spsr),
                    32'(restore_from_spsr_o));
        check_field("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every opcode, across eight shifter forms and with extreme operands
  task automatic test_opcodes();
    logic        imm;
    logic [11:0] op12;
    logic [31:0] rs;
    for (int k = 0; k < 16; k++) begin
      imm = 1'b0;
      rs  = 32'd0;
      case (k % 8)
        0: begin imm = 1'b1; op12 = 12'h0FF; end
        1: begin imm = 1'b1; op12 = 12'h1FF; end
        2: op12 = 12'h005;
        3: op12 = 12'h020;
        4: op12 = 12'h040;
        5: op12 = 12'h060;
        6: begin op12 = 12'h010; rs = 32'd32; end
        default: begin op12 = 12'h070; rs = 32'h0000_0040; end
      endcase
      send_fields(build_instr(imm, opcode_e'(k), 1'b1, (k == 15) ? 4'd14 : 4'(k), op12),
                  (k < 8) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF,
                  (k % 4 == 3) ? 32'h0000_0000 : ((k < 8) ? 32'h8000_0000 : 32'hFFFF_FFFF),
                  rs, (k % 2 == 1) ? 4'hF : 4'h0, 1'(k / 2));
    end
    wait_drain();
  endtask

  task automatic test_special_cases();
    // Compare without S is not data processing
    send_fields(build_instr(1'b0, OPC_CMP, 1'b0, 4'd0, 12'h001), 32'd5, 32'd5, 32'd0, 4'h5, 1'b0);
    // Register shift with bit 7 set
    send_fields(build_instr(1'b0, OPC_ADD, 1'b1, 4'd2, 12'h291), 32'd1, 32'd2, 32'd3, 4'h3, 1'b1);
    // Flag-setting write to PC, with and without an SPSR
    send_fields(build_instr(1'b1, OPC_SUB, 1'b1, REG_PC, 12'h004), 32'h0000_1000, 32'd0,
                32'd0, 4'h6, 1'b1);
    send_fields(build_instr(1'b0, OPC_MOV, 1'b1, REG_PC, 12'h00E), 32'd0, 32'h0000_2000,
                32'd0, 4'h9, 1'b0);
    // Compare naming the PC still sets flags
    send_fields(build_instr(1'b0, OPC_CMP, 1'b1, REG_PC, 12'h000), 32'd0, 32'd0, 32'd0,
                4'h0, 1'b0);
    // Flags held with S clear
    send_fields(build_instr(1'b0, OPC_ADD, 1'b0, 4'd3, 12'h000), 32'hFFFF_FFFF, 32'd1,
                32'd0, 4'hA, 1'b0);
    // LSR by register beyond 32, upper Rs bits set
    send_fields(build_instr(1'b0, OPC_MOV, 1'b1, 4'd4, 12'h031), 32'd0, 32'hFFFF_FFFF,
                32'hFFFF_FF21, 4'h0, 1'b0);
    // ASR #5 of a negative value
    send_fields(build_instr(1'b0, OPC_MOV, 1'b1, 4'd5, 12'h2C0), 32'd0, 32'h8000_0010,
                32'd0, 4'h0, 1'b0);
    // Signed overflow through the carry in
    send_fields(build_instr(1'b0, OPC_ADC, 1'b1, 4'd6, 12'h000), 32'h7FFF_FFFF, 32'd0,
                32'd0, 4'h2, 1'b0);
    wait_drain();
  endtask

  // Hold the result side off while the sender keeps offering items
  task automatic test_backpressure();
    @(posedge clk_i);
    rx_hold_cycles = 80;
    tx_idle_en     = 1'b0;
    repeat (40) send_item(rand_item());
    tx_idle_en = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_mix();
    repeat (430) send_item(rand_item());
    wait_drain();
  endtask

  // Full rate on both sides
  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (50) send_item(rand_item());
    wait_drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    push_i          = 1'b0;
    instruction_i   = '0;
    rn_value_i      = '0;
    rm_value_i      = '0;
    rs_value_i      = '0;
    flags_in_i      = '0;
    mode_has_spsr_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_opcodes();
    test_special_cases();
    test_backpressure();
    test_random_mix();
    test_streaming();

    // Let any stray result surface
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/adpa_pkg.sv
rtl/adpa_fifo.sv
rtl/adpa_front.sv
rtl/adpa_back.sv
rtl/arm_data_processing_alu_top.sv
tb/tb.sv
